// ----- hw/rtl/stp_pkg.sv -----
// shared widths, command codes and defaults for the segment trajectory player
package stp_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;

  localparam int CMD_W  = 2;
  localparam int DELTA_W = 24;
  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int SEG_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REWIND  = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_t;

endpackage

// ----- hw/rtl/stp_in_if.sv -----
// command channel: valid/ready with one append, clear, rewind or advance command per beat
interface stp_in_if;
  import stp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [DELTA_W-1:0]  delta_x;
  logic signed [DELTA_W-1:0]  delta_y;
  logic [TIME_W-1:0]          time_us;

  modport source (output valid, cmd, delta_x, delta_y, time_us, input ready);
  modport sink   (input valid, cmd, delta_x, delta_y, time_us, output ready);
endinterface

// ----- hw/rtl/stp_out_if.sv -----
// position channel: valid/ready with one position report per beat
interface stp_out_if;
  import stp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic [SEG_W-1:0]          segment_now;
  logic                      finished;
  logic                      dropped;

  modport source (output valid, pos_x, pos_y, segment_now, finished, dropped,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, segment_now, finished, dropped,
                  output ready);
endinterface

// ----- hw/rtl/segment_trajectory_player.sv -----
// segment_trajectory_player: stores relative motion segments and reports the
// interpolated position after every command.
// req (sink) takes one command per beat: append a segment (delta_x, delta_y,
// duration time_us), clear the list, rewind, or advance by time_us.
// rsp (source) gives one beat per command: saturated Q24.8 position, current
// segment index, finished and dropped flags.
// append, clear and rewind go from accept through ST_POS, then ST_MUL, ST_DIV
// and ST_SUM for x and for y, to the result register in ST_OUT; with the list
// finished or a zero-duration segment, ST_MUL goes straight to ST_OUT. advance
// first runs ST_ADV_RD for each segment it reaches and ST_ADV_CHK for each one
// still in the list. the position needs two 24 x 32 multiplies and two 24-step
// restoring divisions done one after the other on a single multiplier and a single divider.
// throughput: one command at a time; the next one is taken at the earliest
// the cycle after the previous result is registered.
// req.ready is high only while the sequencer waits for a command; it stays
// high while a finished result waits in the output register, but the next
// result is held back until rsp takes the previous beat.
// segments live in one ram of MAX_SEGMENTS entries, read one entry per cycle.
// synchronous reset empties the list and returns to position zero at once;
// ram contents are left as they are and never read before being written.
module segment_trajectory_player #(
  parameter int MAX_SEGMENTS = stp_pkg::MAX_SEGMENTS_DEF
) (
  input logic clk,
  input logic rst,
  stp_in_if.sink    req,
  stp_out_if.source rsp
);
  import stp_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int RW = 2 * DELTA_W + TIME_W;
  localparam int PW = DELTA_W + TIME_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADV_RD, ST_ADV_CHK, ST_POS, ST_MUL, ST_DIV, ST_SUM, ST_OUT
  } state_t;

  state_t               state;
  logic [CW-1:0]        seg_count;
  logic [CW-1:0]        seg_index;
  logic [TIME_W-1:0]    elapsed_us;
  logic signed [POS_W-1:0] base_x, base_y;
  logic [TIME_W-1:0]    t_left;
  logic                 axis;
  logic                 neg;
  logic [TIME_W-1:0]    rem;
  logic [DELTA_W-1:0]   qbits;
  logic [4:0]           cnt;
  logic signed [POS_W-1:0] px, py;
  logic                 drop;

  // ram
  logic            ram_we;
  logic [RW-1:0]   ram_rdata;
  logic signed [DELTA_W-1:0] rd_dx, rd_dy;
  logic [TIME_W-1:0] rd_dur;

  logic accept;
  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign ram_we = accept && (cmd_t'(req.cmd) == CMD_APPEND) && (seg_count < MAX_CNT);

  stp_ram #(.WIDTH(RW), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seg_count[AW-1:0]),
    .wdata ({req.delta_x, req.delta_y, req.time_us}),
    .raddr (seg_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_dx  = ram_rdata[RW-1 -: DELTA_W];
  assign rd_dy  = ram_rdata[TIME_W +: DELTA_W];
  assign rd_dur = ram_rdata[TIME_W-1:0];

  // datapath pieces
  logic                 active;
  logic [TIME_W-1:0]    seg_left;
  logic signed [DELTA_W-1:0] d_sel;
  logic [DELTA_W-1:0]   d_mag;
  logic [PW-1:0]        prod;
  logic [TIME_W:0]      rem2, dur33, rem_sub;
  logic signed [DELTA_W:0] term;
  logic signed [POS_W-1:0] base_sel, add_a, sat_out;
  logic signed [POS_W:0]   sum;
  logic signed [POS_W-1:0] add_b;

  assign active   = seg_index < seg_count;
  assign seg_left = (rd_dur > elapsed_us) ? rd_dur - elapsed_us : '0;
  assign d_sel    = axis ? rd_dy : rd_dx;
  assign d_mag    = d_sel[DELTA_W-1] ? DELTA_W'(-d_sel) : DELTA_W'(d_sel);
  assign prod     = PW'(d_mag) * PW'(elapsed_us);
  assign rem2     = {rem, qbits[DELTA_W-1]};
  assign dur33    = {1'b0, rd_dur};
  assign rem_sub  = rem2 - dur33;
  assign term     = neg ? -$signed({1'b0, qbits}) : $signed({1'b0, qbits});
  assign base_sel = axis ? base_y : base_x;

  // one saturating adder: base + segment delta while advancing, base + term
  always_comb begin
    if (state == ST_ADV_CHK) begin
      add_a = base_sel;
      add_b = POS_W'(d_sel);
    end else begin
      add_a = base_sel;
      add_b = POS_W'(term);
    end
    sum = (POS_W+1)'(add_a) + (POS_W+1)'(add_b);
    if (sum[POS_W] != sum[POS_W-1]) begin
      sat_out = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_out = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      seg_count  <= '0;
      seg_index  <= '0;
      elapsed_us <= '0;
      base_x     <= '0;
      base_y     <= '0;
      axis       <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != ST_OUT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            drop   <= (cmd_t'(req.cmd) == CMD_APPEND) && (seg_count >= MAX_CNT);
            t_left <= req.time_us;
            axis   <= 1'b0;
            case (cmd_t'(req.cmd))
              CMD_APPEND: begin
                if (seg_count < MAX_CNT) begin
                  seg_count <= seg_count + 1'b1;
                end
                state <= ST_POS;
              end
              CMD_CLEAR: begin
                seg_count  <= '0;
                seg_index  <= '0;
                elapsed_us <= '0;
                base_x     <= '0;
                base_y     <= '0;
                state      <= ST_POS;
              end
              CMD_REWIND: begin
                seg_index  <= '0;
                elapsed_us <= '0;
                base_x     <= '0;
                base_y     <= '0;
                state      <= ST_POS;
              end
              CMD_ADVANCE: state <= ST_ADV_RD;
              default:     state <= ST_POS;
            endcase
          end
        end
        // ram read of the current segment is registered at the end of this state
        ST_ADV_RD: begin
          axis  <= 1'b0;
          state <= active ? ST_ADV_CHK : ST_POS;
        end
        // x adds in the first pass, y in the second
        ST_ADV_CHK: begin
          if (t_left >= seg_left) begin
            if (!axis) begin
              base_x <= sat_out;
              axis   <= 1'b1;
            end else begin
              base_y     <= sat_out;
              seg_index  <= seg_index + 1'b1;
              t_left     <= t_left - seg_left;
              elapsed_us <= '0;
              axis       <= 1'b0;
              state      <= ST_ADV_RD;
            end
          end else begin
            elapsed_us <= elapsed_us + t_left;
            axis       <= 1'b0;
            state      <= ST_POS;
          end
        end
        ST_POS: begin
          axis  <= 1'b0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (active && rd_dur != '0) begin
            neg   <= d_sel[DELTA_W-1];
            rem   <= prod[PW-1 -: TIME_W];
            qbits <= prod[DELTA_W-1:0];
            cnt   <= 5'(DELTA_W - 1);
            state <= ST_DIV;
          end else begin
            px    <= base_x;
            py    <= base_y;
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (rem2 >= dur33) begin
            rem   <= rem_sub[TIME_W-1:0];
            qbits <= {qbits[DELTA_W-2:0], 1'b1};
          end else begin
            rem   <= rem2[TIME_W-1:0];
            qbits <= {qbits[DELTA_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (!axis) begin
            px    <= sat_out;
            axis  <= 1'b1;
            state <= ST_MUL;
          end else begin
            py    <= sat_out;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.pos_x       <= px;
            rsp.pos_y       <= py;
            rsp.segment_now <= SEG_W'(seg_index);
            rsp.finished    <= !active;
            rsp.dropped     <= drop;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_index_in_list: assert property (@(posedge clk) disable iff (rst)
    seg_index <= seg_count) else $error("segment index beyond list");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= MAX_CNT) else $error("segment count beyond store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready) else $error("ready while command in work");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < rd_dur) else $error("divider remainder not below duration");
`endif

endmodule

// ----- hw/rtl/stp_ram.sv -----
// generic single write port ram with registered read
module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
